// ===== sv/m3h_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3h_pkg
// Shared constants and types of the MurmurHash3 x86_32 stream hash core.
// ----------------------------------------------------------------------------
package m3h_pkg;

    localparam logic [31:0] C1 = 32'hCC9E2D51;
    localparam logic [31:0] C2 = 32'h1B873593;
    localparam logic [31:0] N_ADD = 32'hE6546B64;
    localparam logic [31:0] F1 = 32'h85EBCA6B;
    localparam logic [31:0] F2 = 32'hC2B2AE35;

    localparam logic [31:0] SEED_RESET = 32'h0000_0000;
    localparam int QUEUE_DEPTH = 4;

    // APB byte address: bit 2 selects the register, bits 1:0 are ignored
    localparam int ADDR_W = 3;
    localparam logic REG_SEED = 1'b0;

    // One queued command per item that ends a block and/or the message
    typedef struct packed {
        logic        do_block;
        logic        do_tail;
        logic        do_final;
        logic        first;
        logic [31:0] seed;
        logic [31:0] word;
        logic [31:0] length;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== sv/m3h_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3h_in_if / m3h_out_if
// Valid/ready channels for message bytes and hash results.
// ----------------------------------------------------------------------------
interface m3h_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       is_last;

    modport source (output valid, data_byte, carries_byte, is_last, input ready);
    modport sink (input valid, data_byte, carries_byte, is_last, output ready);
endinterface

interface m3h_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink (input valid, hash_value, output ready);
endinterface

// ===== sv/m3h_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3h_front
// Accepts message bytes, packs them into little-endian blocks and counts the
// length; pushes one command per finished block and/or message end.
// ----------------------------------------------------------------------------
module m3h_front
(
    input  logic              clk,
    input  logic              rst_n,
    m3h_in_if.sink            msg,
    input  logic [31:0]       seed,
    input  logic              q_full,
    output logic              push,
    output m3h_pkg::cmd_t     cmd
);

    logic [23:0] partial_reg;
    logic [1:0]  pos_reg;
    logic [31:0] len_reg;
    logic        started_reg;
    logic        first_reg;
    logic [31:0] seed_hold_reg;

    logic        accept;
    logic        has;
    logic        last;
    logic        block;
    logic [23:0] partial_next;
    logic [1:0]  pos_next;
    logic [31:0] len_next;
    logic [31:0] seed_msg;

    assign msg.ready = !q_full;
    assign accept    = msg.valid && msg.ready;
    assign has       = msg.carries_byte;
    assign last      = msg.is_last;
    assign block     = has && (pos_reg == 2'd3);
    assign seed_msg  = started_reg ? seed_hold_reg : seed;

    always_comb
    begin
        partial_next = partial_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        if (has)
        begin
            len_next = len_reg + 32'd1;
            pos_next = pos_reg + 2'd1;
            case (pos_reg)
                2'd0:    partial_next = {16'h0000, msg.data_byte};
                2'd1:    partial_next = {8'h00, msg.data_byte, partial_reg[7:0]};
                2'd2:    partial_next = {msg.data_byte, partial_reg[15:0]};
                default: partial_next = 24'h000000;
            endcase
        end
    end

    assign push = accept && (block || last);

    always_comb
    begin
        cmd.do_block = block;
        cmd.do_tail  = last && (pos_next != 2'd0);
        cmd.do_final = last;
        cmd.first    = first_reg;
        cmd.seed     = seed_msg;
        cmd.word     = block ? {msg.data_byte, partial_reg} : {8'h00, partial_next};
        cmd.length   = len_next;
    end

    // Freeze the message seed once the first byte is in
    always_ff @(posedge clk)
    begin
        if (accept && has && !started_reg)
        begin
            seed_hold_reg <= seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 24'h000000;
            pos_reg     <= 2'd0;
            len_reg     <= 32'd0;
            started_reg <= 1'b0;
            first_reg   <= 1'b1;
        end
        else if (accept)
        begin
            if (last)
            begin
                partial_reg <= 24'h000000;
                pos_reg     <= 2'd0;
                len_reg     <= 32'd0;
                started_reg <= 1'b0;
                first_reg   <= 1'b1;
            end
            else
            begin
                partial_reg <= partial_next;
                pos_reg     <= pos_next;
                len_reg     <= len_next;
                if (has)
                begin
                    started_reg <= 1'b1;
                end
                if (push)
                begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== sv/m3h_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3h_queue
// Small command FIFO between the byte front and the mixing back.
// ----------------------------------------------------------------------------
module m3h_queue
#(
    parameter int DEPTH = m3h_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  m3h_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output m3h_pkg::cmd_t        head,
    output m3h_pkg::queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    m3h_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/m3h_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3h_back
// Sequencer that runs block scrambles, tail mix and the final avalanche, at most
// one constant multiply per cycle, and holds the result in an output register.
// ----------------------------------------------------------------------------
module m3h_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  m3h_pkg::cmd_t     head,
    input  logic              q_empty,
    output logic              pop,
    output logic              busy,
    m3h_out_if.source         hash
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_MIX,
        S_F1,
        S_F2,
        S_OUT
    } state_t;

    state_t        state_reg;
    logic          valid_reg;
    logic [31:0]   hash_reg;

    m3h_pkg::cmd_t cmd_reg;
    logic [31:0]   h_reg;
    logic [31:0]   t_reg;

    logic [31:0]   k_rot;
    logic [31:0]   hx;
    logic [31:0]   hx_rot;
    logic [31:0]   f1_in;
    logic [31:0]   f2_in;

    assign pop        = (state_reg == S_IDLE) && !q_empty;
    assign busy       = (state_reg != S_IDLE);
    assign hash.valid = valid_reg;
    assign hash.hash_value = hash_reg;

    assign k_rot  = {t_reg[16:0], t_reg[31:17]};
    assign hx     = h_reg ^ t_reg;
    assign hx_rot = {hx[18:0], hx[31:19]};
    assign f1_in  = (h_reg ^ cmd_reg.length) ^ ((h_reg ^ cmd_reg.length) >> 16);
    assign f2_in  = t_reg ^ (t_reg >> 13);

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                // take the head only when it is popped
                if (!q_empty)
                begin
                    cmd_reg <= head;
                    if (head.first)
                    begin
                        h_reg <= head.seed;
                    end
                end
            end
            S_K1:
            begin
                t_reg <= cmd_reg.word * m3h_pkg::C1;
            end
            S_K2:
            begin
                t_reg <= k_rot * m3h_pkg::C2;
            end
            S_MIX:
            begin
                if (cmd_reg.do_block)
                begin
                    h_reg <= hx_rot + {hx_rot[29:0], 2'b00} + m3h_pkg::N_ADD;
                end
                else
                begin
                    h_reg <= hx;
                end
            end
            S_F1:
            begin
                t_reg <= f1_in * m3h_pkg::F1;
            end
            S_F2:
            begin
                t_reg <= f2_in * m3h_pkg::F2;
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            hash_reg  <= 32'h0000_0000;
        end
        else
        begin
            // hold until the previous result is taken
            if ((state_reg == S_OUT) && (!valid_reg || hash.ready))
            begin
                valid_reg <= 1'b1;
                hash_reg  <= t_reg ^ (t_reg >> 16);
            end
            else if (valid_reg && hash.ready)
            begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (head.do_block || head.do_tail)
                        begin
                            state_reg <= S_K1;
                        end
                        else if (head.do_final)
                        begin
                            state_reg <= S_F1;
                        end
                    end
                end
                S_K1:
                begin
                    state_reg <= S_K2;
                end
                S_K2:
                begin
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    state_reg <= cmd_reg.do_final ? S_F1 : S_IDLE;
                end
                S_F1:
                begin
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!valid_reg || hash.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/murmur3_32_stream_hash_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash_core
// MurmurHash3 x86_32 over a byte stream, at most one byte per item, seed over APB.
// ----------------------------------------------------------------------------
// The front takes one item per cycle as long as the command queue has room;
// every fourth byte and every message end post a command. The back runs each
// command on one shared-style chain of registered constant multiplies: a full
// block takes a pop, two scramble multiplies and a hash round, a tail the
// same, and a message end adds the avalanche (two multiplies, then the output
// register), so long messages stream at about one byte per cycle while the
// hash output is not held back. The seed at address 0 is sampled when a
// message takes its first byte; writing it mid-message affects the next
// message only.
module murmur3_32_stream_hash_core
#(
    parameter int QUEUE_DEPTH = m3h_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    m3h_in_if.sink                      msg,
    m3h_out_if.source                   hash,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [m3h_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [31:0]          seed_reg;
    logic                 cfg_wr;
    logic                 q_push;
    logic                 q_pop;
    logic                 back_busy;
    m3h_pkg::cmd_t        push_cmd;
    m3h_pkg::cmd_t        head;
    m3h_pkg::queue_stat_t q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == m3h_pkg::REG_SEED) ? seed_reg : 32'h0000_0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= m3h_pkg::SEED_RESET;
        end
        else if (cfg_wr && (paddr[2] == m3h_pkg::REG_SEED))
        begin
            seed_reg <= pwdata;
        end
    end

    m3h_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .seed   (seed_reg),
        .q_full (q_stat.full),
        .push   (q_push),
        .cmd    (push_cmd)
    );

    m3h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .stat     (q_stat)
    );

    m3h_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_stat.empty),
        .pop     (q_pop),
        .busy    (back_busy),
        .hash    (hash)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !back_busy)
        else $error("command popped while back end busy");

    a_busy_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && (head.do_block || head.do_tail || head.do_final) |=> back_busy)
        else $error("back end did not start on a popped command");

endmodule
